/* src/spq_pkg.sv */
// shared types and codes for the sorted priority queue
package spq_pkg;

    localparam int TAG_BITS  = 16;
    localparam int PRIO_BITS = 16;
    localparam int OCC_BITS  = 5;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic                        req_type;
        logic [TAG_BITS-1:0]         job_tag;
        logic signed [PRIO_BITS-1:0] job_priority;
    } req_t;

    typedef struct packed {
        status_t                     status;
        logic [TAG_BITS-1:0]         out_tag;
        logic signed [PRIO_BITS-1:0] out_priority;
        logic [OCC_BITS-1:0]         occupancy;
    } rsp_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]         tag;
        logic signed [PRIO_BITS-1:0] prio;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   insert;
        logic   pop;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

/* src/spq_cell.sv */
// one slot of the sorted chain: compare, hold, take new job or shift
module spq_cell
    import spq_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       prev_stays,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    output entry_t     entry,
    output logic       stays
);

    entry_t entry_reg;
    entry_t entry_next;

    // job stays put on insert when it ranks equal or higher than the new one
    assign stays = occupied &&
                   ($signed(entry_reg.prio) >= $signed(ctrl.new_entry.prio));

    // insert point is the first cell that does not stay, cells after it shift right
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.insert) begin
            if (!stays) begin
                entry_next = prev_stays ? ctrl.new_entry : left_entry;
            end
        end else if (ctrl.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* src/sorted_priority_queue_top.sv */
// Sorted priority queue top: a chain of compare-and-shift cells with a result register.
// The result beat is registered and appears in the cycle after the request beat is accepted.
// Throughput: one request per cycle while results are taken; every cell compares and shifts in the same cycle.
// A result waiting on m_ready holds off the next request until that result is taken.
// Reset clears the job count and the output valid; slot contents are not cleared.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    rsp_t             m_data_reg;
    rsp_t             m_data_next;

    logic       in_fire;
    logic       is_pop;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;

    entry_t             cell_entry [DEPTH];
    logic [DEPTH-1:0]   cell_stays;
    logic [DEPTH-1:0]   cell_occ;
    logic [CNT_W+OCC_BITS-1:0] occ_ext;

    // request decode
    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;
    assign is_pop  = (s_data.req_type == REQ_POP);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    assign ctrl.insert        = in_fire && !is_pop && !full;
    assign ctrl.pop           = in_fire && is_pop && !empty;
    assign ctrl.new_entry.tag  = s_data.job_tag;
    assign ctrl.new_entry.prio = s_data.job_priority;

    // occupied flags, one compare per cell
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_occ[i] = (CNT_W'(i) < count_reg);
        end
    end

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic   prev_stays;
        entry_t left_entry;
        entry_t right_entry;

        if (g == 0) begin : g_first
            assign prev_stays = 1'b1;
            assign left_entry = '0;
        end else begin : g_mid
            assign prev_stays = cell_stays[g-1];
            assign left_entry = cell_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = cell_entry[g+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (cell_occ[g]),
            .prev_stays  (prev_stays),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[g]),
            .stays       (cell_stays[g])
        );
    end

    // count update
    always_comb begin
        count_next = count_reg;
        if (ctrl.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign occ_ext = {{OCC_BITS{1'b0}}, count_next};

    // result beat
    always_comb begin
        m_data_next              = '0;
        m_data_next.status       = STATUS_OK;
        m_data_next.occupancy    = occ_ext[OCC_BITS-1:0];
        if (is_pop) begin
            if (empty) begin
                m_data_next.status = STATUS_UNDERFLOW;
            end else begin
                m_data_next.out_tag      = cell_entry[0].tag;
                m_data_next.out_priority = cell_entry[0].prio;
            end
        end else if (full) begin
            m_data_next.status = STATUS_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (in_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("job count above depth");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && is_pop && !empty) |=>
            (count_reg == $past(count_reg) - CNT_W'(1)) && (m_data.status == STATUS_OK))
        else $error("pop did not remove exactly one job");

    a_full_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !is_pop && full) |=>
            (count_reg == $past(count_reg)) && (m_data.status == STATUS_FULL))
        else $error("insert into full queue not refused");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STATUS_OK) |->
            (m_data.out_tag == '0) && (m_data.out_priority == '0))
        else $error("error result carries job data");

endmodule
